// File: hdl/blob_centroid_radius_macros.svh
// assertion macros for the blob centroid block
`ifndef BLOB_CENTROID_RADIUS_MACROS_SVH
`define BLOB_CENTROID_RADIUS_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BCR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bcr same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define BCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bcr next-cycle check failed");

`endif

// File: hdl/bcr_pkg.sv
// ----------------------------------------------------------------------------
// bcr_pkg
// Shared widths, constants and types of the blob centroid and radius block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcr_pkg;

	localparam int PIX_W    = 8;
	localparam int COORD_W  = 10;
	localparam int AREA_W   = 21;
	localparam int SUM_W    = 30;
	localparam int RADIUS_W = 9;
	localparam int SPAN_W   = COORD_W + 1;

	localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd128;
	localparam logic [PIX_W-1:0] PIX_ON          = 8'd255;
	localparam logic [PIX_W-1:0] PIX_OFF         = 8'd0;

	localparam int MAX_ROWS_DEFAULT    = 1024;
	localparam int MAX_COLUMNS_DEFAULT = 1024;

	// entries of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// one accepted pixel plus a snapshot of the frame statistics
	typedef struct packed {
		logic               pix_on;
		logic               last;
		logic               seen;
		logic [AREA_W-1:0]  area;
		logic [SUM_W-1:0]   row_sum;
		logic [SUM_W-1:0]   column_sum;
		logic [COORD_W-1:0] min_row;
		logic [COORD_W-1:0] max_row;
		logic [COORD_W-1:0] min_column;
		logic [COORD_W-1:0] max_column;
	} bcr_rec_t;

	typedef enum logic [0:0] {
		BCR_IDLE,
		BCR_DIV
	} bcr_state_t;

	typedef struct packed {
		bcr_state_t state;
		logic       div_done;
	} bcr_back_stat_t;

endpackage

`default_nettype wire

// File: hdl/blob_centroid_radius.sv
// ----------------------------------------------------------------------------
// blob_centroid_radius
// Binarizes a grey pixel stream and reports centroid and radius per frame.
// ----------------------------------------------------------------------------
// Usage:
// - input queue side: drive pixel_value, row_index, column_index, frame_end
//   and raise push; a transaction happens on an edge with push high and full
//   low. full rises only when the four-entry internal queue is occupied.
// - result side: while empty is low the oldest result is on the outputs; a
//   transaction happens on an edge with pop high and empty low.
// - every pixel yields one result; the pixel flagged frame_end also carries
//   summary_valid, empty_frame, center_row, center_column and radius.
// - an ordinary pixel's result passes the queue and the output register; a
//   frame's last pixel with object pixels also waits for the two bit-serial
//   dividers (one quotient bit per cycle, 30 bits).
// - throughput: one pixel per cycle inside a frame while pop stays high; the
//   frame's last pixel holds the back end for division while the queue accepts.
// - cfg_write loads the threshold from cfg_data in the same edge; write it
//   only while the block is idle.
// - reset clears all statistics and sets the threshold to 128; a stalled
//   result side fills the queue and then raises full, nothing is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "blob_centroid_radius_macros.svh"

module blob_centroid_radius #(
	parameter int MAX_ROWS    = bcr_pkg::MAX_ROWS_DEFAULT,
	parameter int MAX_COLUMNS = bcr_pkg::MAX_COLUMNS_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic [bcr_pkg::PIX_W-1:0]     cfg_data,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [bcr_pkg::PIX_W-1:0]     pixel_value,
	input  wire logic [bcr_pkg::COORD_W-1:0]   row_index,
	input  wire logic [bcr_pkg::COORD_W-1:0]   column_index,
	input  wire logic                          frame_end,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [bcr_pkg::PIX_W-1:0]          binary_pixel,
	output logic                               summary_valid,
	output logic                               empty_frame,
	output logic [bcr_pkg::COORD_W-1:0]        center_row,
	output logic [bcr_pkg::COORD_W-1:0]        center_column,
	output logic [bcr_pkg::RADIUS_W-1:0]       radius
);

	localparam int Q_CNT_W = $clog2(bcr_pkg::QUEUE_DEPTH+1);

	bcr_pkg::bcr_rec_t       front_rec, q_rec;
	bcr_pkg::bcr_back_stat_t back_stat;
	logic                    accept, q_empty, q_pop;
	logic [Q_CNT_W-1:0]      q_count;

	assign accept = push && !full;

	bcr_front #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.pixel_value  (pixel_value),
		.row_index    (row_index),
		.column_index (column_index),
		.frame_end    (frame_end),
		.rec          (front_rec)
	);

	bcr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (front_rec),
		.rd_en   (q_pop),
		.rd_data (q_rec),
		.full    (full),
		.empty   (q_empty),
		.count   (q_count)
	);

	bcr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec           (q_rec),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.binary_pixel  (binary_pixel),
		.summary_valid (summary_valid),
		.empty_frame   (empty_frame),
		.center_row    (center_row),
		.center_column (center_column),
		.radius        (radius),
		.stat          (back_stat)
	);

	// queue occupancy never goes past its depth
	`BCR_ASSERT_IMPL(a_queue_bound, clk, arst_n, 1'b1, q_count <= Q_CNT_W'(bcr_pkg::QUEUE_DEPTH))

	// an idle back end with work waiting and a free output makes progress
	`BCR_ASSERT_NEXT(a_back_moves, clk, arst_n, back_stat.state == bcr_pkg::BCR_IDLE && !q_empty && empty, !empty || back_stat.state == bcr_pkg::BCR_DIV)

	// leaving the division state always delivers a result
	`BCR_ASSERT_NEXT(a_div_delivers, clk, arst_n, back_stat.state == bcr_pkg::BCR_DIV, back_stat.state == bcr_pkg::BCR_DIV || !empty)

	// an empty frame is a summary with zero geometry
	`BCR_ASSERT_IMPL(a_empty_frame, clk, arst_n, !empty && empty_frame, summary_valid && radius == '0 && center_row == '0 && center_column == '0)

endmodule

`default_nettype wire

// File: hdl/bcr_front.sv
// ----------------------------------------------------------------------------
// bcr_front
// Thresholds each pixel and accumulates area, sums and extremes of the frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcr_front #(
	parameter int MAX_ROWS    = bcr_pkg::MAX_ROWS_DEFAULT,
	parameter int MAX_COLUMNS = bcr_pkg::MAX_COLUMNS_DEFAULT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_write,
	input  wire logic [bcr_pkg::PIX_W-1:0]    cfg_data,
	input  wire logic                         accept,
	input  wire logic [bcr_pkg::PIX_W-1:0]    pixel_value,
	input  wire logic [bcr_pkg::COORD_W-1:0]  row_index,
	input  wire logic [bcr_pkg::COORD_W-1:0]  column_index,
	input  wire logic                         frame_end,
	output bcr_pkg::bcr_rec_t                 rec
);

	localparam logic [bcr_pkg::AREA_W-1:0] AREA_MAX = '1;
	localparam logic [bcr_pkg::SUM_W-1:0]  SUM_MAX  = '1;

	logic [bcr_pkg::PIX_W-1:0]   threshold_q;
	logic [bcr_pkg::AREA_W-1:0]  area_q, area_nx;
	logic [bcr_pkg::SUM_W-1:0]   row_sum_q, row_sum_nx;
	logic [bcr_pkg::SUM_W-1:0]   column_sum_q, column_sum_nx;
	logic [bcr_pkg::COORD_W-1:0] min_row_q, min_row_nx, max_row_q, max_row_nx;
	logic [bcr_pkg::COORD_W-1:0] min_column_q, min_column_nx;
	logic [bcr_pkg::COORD_W-1:0] max_column_q, max_column_nx;
	logic                        seen_q, seen_nx;
	logic                        obj, hit;
	logic [bcr_pkg::SUM_W:0]     row_add, column_add;

	assign obj = pixel_value > threshold_q;
	// pixels outside the frame are binarized but never accumulated
	assign hit = obj && (32'(row_index) < 32'(MAX_ROWS))
		&& (32'(column_index) < 32'(MAX_COLUMNS));

	assign row_add    = {1'b0, row_sum_q} + (bcr_pkg::SUM_W+1)'(row_index);
	assign column_add = {1'b0, column_sum_q} + (bcr_pkg::SUM_W+1)'(column_index);

	always_comb begin
		area_nx       = area_q;
		row_sum_nx    = row_sum_q;
		column_sum_nx = column_sum_q;
		min_row_nx    = min_row_q;
		max_row_nx    = max_row_q;
		min_column_nx = min_column_q;
		max_column_nx = max_column_q;
		seen_nx       = seen_q;
		if (hit) begin
			area_nx       = (area_q == AREA_MAX) ? AREA_MAX : area_q + 1'b1;
			row_sum_nx    = row_add[bcr_pkg::SUM_W] ? SUM_MAX : row_add[bcr_pkg::SUM_W-1:0];
			column_sum_nx = column_add[bcr_pkg::SUM_W] ? SUM_MAX
				: column_add[bcr_pkg::SUM_W-1:0];
			if (row_index < min_row_q) min_row_nx = row_index;
			if (row_index > max_row_q) max_row_nx = row_index;
			if (column_index < min_column_q) min_column_nx = column_index;
			if (column_index > max_column_q) max_column_nx = column_index;
			seen_nx = 1'b1;
		end
	end

	always_comb begin
		rec.pix_on     = obj;
		rec.last       = frame_end;
		rec.seen       = seen_nx;
		rec.area       = area_nx;
		rec.row_sum    = row_sum_nx;
		rec.column_sum = column_sum_nx;
		rec.min_row    = min_row_nx;
		rec.max_row    = max_row_nx;
		rec.min_column = min_column_nx;
		rec.max_column = max_column_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= bcr_pkg::THRESHOLD_RESET;
		end else if (cfg_write) begin
			threshold_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q       <= '0;
			row_sum_q    <= '0;
			column_sum_q <= '0;
			min_row_q    <= '1;
			max_row_q    <= '0;
			min_column_q <= '1;
			max_column_q <= '0;
			seen_q       <= 1'b0;
		end else if (accept) begin
			if (frame_end) begin
				// snapshot went to the queue, start the next frame clean
				area_q       <= '0;
				row_sum_q    <= '0;
				column_sum_q <= '0;
				min_row_q    <= '1;
				max_row_q    <= '0;
				min_column_q <= '1;
				max_column_q <= '0;
				seen_q       <= 1'b0;
			end else begin
				area_q       <= area_nx;
				row_sum_q    <= row_sum_nx;
				column_sum_q <= column_sum_nx;
				min_row_q    <= min_row_nx;
				max_row_q    <= max_row_nx;
				min_column_q <= min_column_nx;
				max_column_q <= max_column_nx;
				seen_q       <= seen_nx;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/bcr_queue.sv
// ----------------------------------------------------------------------------
// bcr_queue
// Short register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcr_queue (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr_en,
	input  wire bcr_pkg::bcr_rec_t wr_data,
	input  wire logic   rd_en,
	output bcr_pkg::bcr_rec_t rd_data,
	output logic        full,
	output logic        empty,
	output logic [$clog2(bcr_pkg::QUEUE_DEPTH+1)-1:0] count
);

	localparam int DEPTH = bcr_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	bcr_pkg::bcr_rec_t  slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr, do_rd;

	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign count = count_q;
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/bcr_div.sv
// ----------------------------------------------------------------------------
// bcr_div
// Restoring divider, one quotient bit per cycle, sum over area.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcr_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [bcr_pkg::SUM_W-1:0]   dividend,
	input  wire logic [bcr_pkg::AREA_W-1:0]  divisor,
	output logic                             done,
	output logic [bcr_pkg::SUM_W-1:0]        quotient
);

	localparam int NUM_W = bcr_pkg::SUM_W;
	localparam int DEN_W = bcr_pkg::AREA_W;
	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q, rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial, diff;
	logic             ge;

	// remainder stays below the divisor, so the trial value fits one extra bit
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	assign done     = !busy_q;
	assign quotient = num_q;

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(NUM_W-1)) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/bcr_back.sv
// ----------------------------------------------------------------------------
// bcr_back
// Drains the queue, divides on a non-empty frame's last pixel, holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcr_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bcr_pkg::bcr_rec_t             rec,
	input  wire logic                          q_empty,
	output logic                               q_pop,
	input  wire logic                          pop,
	output logic                               empty,
	output logic [bcr_pkg::PIX_W-1:0]          binary_pixel,
	output logic                               summary_valid,
	output logic                               empty_frame,
	output logic [bcr_pkg::COORD_W-1:0]        center_row,
	output logic [bcr_pkg::COORD_W-1:0]        center_column,
	output logic [bcr_pkg::RADIUS_W-1:0]       radius,
	output bcr_pkg::bcr_back_stat_t            stat
);

	localparam int CW = bcr_pkg::COORD_W;
	localparam int SW = bcr_pkg::SUM_W;

	bcr_pkg::bcr_state_t               state_q, state_d;
	logic                              out_valid_q, out_free;
	logic                              div_start, div_done, row_done, column_done;
	logic                              load_direct, load_div;
	logic [SW-1:0]                     row_quo, column_quo;
	logic [CW-1:0]                     row_mean, column_mean;
	logic [bcr_pkg::SPAN_W-1:0]        span;
	logic                              hold_pix_q;
	logic [bcr_pkg::RADIUS_W-1:0]      hold_radius_q;

	bcr_div u_row_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rec.row_sum),
		.divisor  (rec.area),
		.done     (row_done),
		.quotient (row_quo)
	);

	bcr_div u_column_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rec.column_sum),
		.divisor  (rec.area),
		.done     (column_done),
		.quotient (column_quo)
	);

	assign div_done = row_done && column_done;
	assign out_free = !out_valid_q || pop;
	assign empty    = !out_valid_q;

	assign span = bcr_pkg::SPAN_W'(rec.max_column - rec.min_column)
		+ bcr_pkg::SPAN_W'(rec.max_row - rec.min_row);

	// a mean above the coordinate range clamps to all ones
	assign row_mean    = (row_quo[SW-1:CW] != '0) ? '1 : row_quo[CW-1:0];
	assign column_mean = (column_quo[SW-1:CW] != '0) ? '1 : column_quo[CW-1:0];

	assign stat.state    = state_q;
	assign stat.div_done = div_done;

	always_comb begin
		state_d     = state_q;
		q_pop       = 1'b0;
		div_start   = 1'b0;
		load_direct = 1'b0;
		load_div    = 1'b0;
		case (state_q)
			bcr_pkg::BCR_IDLE: begin
				if (!q_empty && out_free) begin
					q_pop = 1'b1;
					if (rec.last && rec.seen) begin
						div_start = 1'b1;
						state_d   = bcr_pkg::BCR_DIV;
					end else begin
						load_direct = 1'b1;
					end
				end
			end
			bcr_pkg::BCR_DIV: begin
				if (div_done && out_free) begin
					load_div = 1'b1;
					state_d  = bcr_pkg::BCR_IDLE;
				end
			end
			default: begin
				state_d = bcr_pkg::BCR_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bcr_pkg::BCR_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_direct || load_div) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			hold_pix_q    <= rec.pix_on;
			hold_radius_q <= span[bcr_pkg::SPAN_W-1:2];
		end
		if (load_direct) begin
			// a last pixel without object pixels is an empty frame
			binary_pixel  <= rec.pix_on ? bcr_pkg::PIX_ON : bcr_pkg::PIX_OFF;
			summary_valid <= rec.last;
			empty_frame   <= rec.last;
			center_row    <= '0;
			center_column <= '0;
			radius        <= '0;
		end else if (load_div) begin
			binary_pixel  <= hold_pix_q ? bcr_pkg::PIX_ON : bcr_pkg::PIX_OFF;
			summary_valid <= 1'b1;
			empty_frame   <= 1'b0;
			center_row    <= row_mean;
			center_column <= column_mean;
			radius        <= hold_radius_q;
		end
	end

endmodule

`default_nettype wire
